>>> rtl/core/csha_pkg.sv
// Shared types and constants for the cross spectrum / histogram accumulator.
// Used by csha_ctrl, csha_datapath and the top level.
package csha_pkg;

   localparam int HIST_BINS      = 256;
   localparam int NUM_QUANTITIES = 4;
   localparam int HIST_DEPTH     = HIST_BINS * NUM_QUANTITIES;
   localparam int HIST_AW        = 10;
   localparam int SUM_W          = 25;
   localparam int HIST_W         = 26;
   localparam int VAL_W          = 27;
   localparam int PKT_W          = 16;
   localparam int CSR_AW         = 4;
   localparam int REQ_DW         = 80;
   localparam int RSP_DW         = 48;
   localparam logic [7:0] SIGN_OFFSET = 8'h80;

   typedef enum logic [1:0] {
      MODE_ACC   = 2'd0,
      MODE_RSPEC = 2'd1,
      MODE_RHIST = 2'd2,
      MODE_CLR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_INTEG    = 2'd0,
      REG_HIST_LOW = 2'd1,
      REG_HIST_HI  = 2'd2,
      REG_NONE     = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [15:0] integrate_count;
      logic [9:0]  hist_chan_low;
      logic [10:0] hist_chan_high;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request payload
      logic clr_init;   // zero counters, restart sweep
      logic clr_step;   // write one zero entry
      logic mem_rd;
      logic mem_wr;
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      mode_type mode;
      logic     complete;
      logic     op_last;
      logic     clr_last;
   } sts_type;

endpackage

>>> rtl/core/cross_spectrum_histogram_accumulator.sv
// Accumulates channel pairs into four per-channel spectra and four 256-bin
// histograms; one response per request. An accumulate request runs eight
// read-modify-write steps on the single-port memories between intake and
// handoff; a read request does one read, a dropped accumulate none.
// A clear request and reset both sweep max(4*2^ceil(log2(MAX_CHANNELS)), 1024)
// memory entries, one per cycle (4096 at the default), during which no request
// is taken; CSR writes are taken at any time. Depends on csha_pkg, csha_ctrl,
// csha_datapath.
module cross_spectrum_histogram_accumulator #(
   parameter int MAX_CHANNELS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] pp_even, [15:8] pp_odd, [23:16] qq_even, [31:24] qq_odd,
   // [39:32] cross_re_even, [47:40] cross_im_even, [55:48] cross_re_odd,
   // [63:56] cross_im_odd, [65:64] read_quantity, [75:66] read_index, rest zero
   input  logic [csha_pkg::REQ_DW-1:0] req_tdata,
   input  logic        req_tlast,
   // [1:0] mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [26:0] read_value, [42:27] packets_integrated, [43] integration_complete,
   // [44] item_dropped, rest zero
   output logic [csha_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [csha_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import csha_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   sts_type sts;
   reg_idx_type csr_idx;
   logic signed [VAL_W-1:0] value;
   logic [PKT_W-1:0] packets;
   logic complete, dropped;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_idx_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_idx)
            REG_INTEG:    cfg_in.integrate_count = csr_pwdata[15:0];
            REG_HIST_LOW: cfg_in.hist_chan_low   = csr_pwdata[9:0];
            REG_HIST_HI:  cfg_in.hist_chan_high  = csr_pwdata[10:0];
            REG_NONE:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_INTEG:    csr_prdata = 32'(cfg_ff.integrate_count);
         REG_HIST_LOW: csr_prdata = 32'(cfg_ff.hist_chan_low);
         REG_HIST_HI:  csr_prdata = 32'(cfg_ff.hist_chan_high);
         REG_NONE:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.integrate_count <= 16'd1;
         cfg_ff.hist_chan_low   <= 10'd160;
         cfg_ff.hist_chan_high  <= 11'd900;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (mode_type'(req_tuser)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   csha_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .cfg          (cfg_ff),
      .req_mode     (req_tuser),
      .req_samples  (req_tdata[63:0]),
      .req_last     (req_tlast),
      .req_quantity (req_tdata[65:64]),
      .req_index    (req_tdata[75:66]),
      .rsp_value    (value),
      .rsp_packets  (packets),
      .rsp_complete (complete),
      .rsp_dropped  (dropped)
   );

   assign rsp_tdata = {3'b000, dropped, complete, packets, value};

endmodule

>>> rtl/core/csha_ctrl.sv
// Sequencer for the accumulator: request intake, read-modify-write steps,
// clearing sweep and result handoff. Depends on csha_pkg.
module csha_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  csha_pkg::mode_type req_mode,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  csha_pkg::sts_type sts,
   output csha_pkg::cmd_type cmd
);
   import csha_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CLEAR = 5'b00010,
      S_RD    = 5'b00100,
      S_WR    = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      boot_ff, boot_in;
   logic      vld_ff, vld_in;
   logic      take;
   logic      out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = vld_ff;
   assign out_free   = !vld_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      boot_in  = boot_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.load = 1'b1;
               unique case (req_mode)
                  MODE_ACC:   state_in = sts.complete ? S_DONE : S_RD;
                  MODE_RSPEC: state_in = S_RD;
                  MODE_RHIST: state_in = S_RD;
                  MODE_CLR: begin
                     cmd.clr_init = 1'b1;
                     state_in     = S_CLEAR;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? S_IDLE : S_DONE;
            end
         end
         S_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = (sts.mode == MODE_ACC) ? S_WR : S_DONE;
         end
         S_WR: begin
            cmd.mem_wr = 1'b1;
            if (sts.op_last) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.out_load) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         boot_ff  <= 1'b1;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

>>> rtl/core/csha_datapath.sv
// Datapath: request register, spectrum and histogram memories with saturating
// update, pair/packet counters, clearing sweep and result register. Uses csha_pkg.
module csha_datapath #(
   parameter int MAX_CHANNELS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  csha_pkg::cmd_type         cmd,
   output csha_pkg::sts_type         sts,
   input  csha_pkg::cfg_type         cfg,
   input  logic [1:0]                req_mode,
   input  logic [63:0]               req_samples,
   input  logic                      req_last,
   input  logic [1:0]                req_quantity,
   input  logic [9:0]                req_index,
   output logic signed [csha_pkg::VAL_W-1:0] rsp_value,
   output logic [csha_pkg::PKT_W-1:0] rsp_packets,
   output logic                      rsp_complete,
   output logic                      rsp_dropped
);
   import csha_pkg::*;

   localparam int CW         = (MAX_CHANNELS > 2) ? $clog2(MAX_CHANNELS) : 1;
   localparam int PAIRS      = MAX_CHANNELS / 2;
   localparam int PW         = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int SAW        = CW + 2;
   localparam int SPEC_DEPTH = 1 << SAW;
   localparam int CLR_LEN    = (SPEC_DEPTH > HIST_DEPTH) ? SPEC_DEPTH : HIST_DEPTH;
   localparam int CLW        = $clog2(CLR_LEN);

   logic signed [SUM_W-1:0] spec_mem [SPEC_DEPTH];
   logic [HIST_W-1:0]       hist_mem [HIST_DEPTH];

   mode_type    mode_ff;
   logic [63:0] smp_ff;
   logic        last_ff;
   logic [1:0]  rq_ff;
   logic [9:0]  ri_ff;
   logic        drop_ff;
   logic [2:0]  op_ff, op_in;
   logic [PW-1:0] pair_ff, pair_in;
   logic [PKT_W-1:0] pkt_ff, pkt_in;
   logic        cmpl_ff, cmpl_in;
   logic [CLW-1:0] clr_ff, clr_in;
   logic signed [SUM_W-1:0] spec_rd_ff;
   logic [HIST_W-1:0]       hist_rd_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [PKT_W-1:0]        opkt_ff;
   logic                    ocmpl_ff, odrop_ff;

   logic [12:0]   ev, ri_ext;
   logic          hist_en, spec_ok, hist_ok;
   logic [7:0]    smp;
   logic signed [8:0] inc;
   logic [CW-1:0] chan;
   logic [SAW-1:0] spec_addr;
   logic [HIST_AW-1:0] hist_addr;
   logic signed [SUM_W:0] sum;
   logic signed [SUM_W-1:0] sum_sat;
   logic [HIST_W-1:0] hist_inc;
   logic signed [VAL_W-1:0] val;
   logic [PKT_W-1:0] pkt_next;

   assign ev      = 13'({pair_ff, 1'b0});
   assign hist_en = (ev > 13'(cfg.hist_chan_low)) && (ev < 13'(cfg.hist_chan_high));
   assign ri_ext  = 13'(ri_ff);
   assign spec_ok = ri_ext < 13'(MAX_CHANNELS);
   assign hist_ok = ri_ext < 13'(HIST_BINS);

   // op k: quantity k[2:1], odd channel when k[0]; sample byte of that quantity and channel
   always_comb begin
      unique case (op_ff)
         3'd0: smp = smp_ff[7:0];     // pp even
         3'd1: smp = smp_ff[15:8];    // pp odd
         3'd2: smp = smp_ff[23:16];   // qq even
         3'd3: smp = smp_ff[31:24];   // qq odd
         3'd4: smp = smp_ff[39:32];   // re even
         3'd5: smp = smp_ff[55:48];   // re odd
         3'd6: smp = smp_ff[47:40];   // im even
         3'd7: smp = smp_ff[63:56];   // im odd
         default: smp = '0;
      endcase
   end

   always_comb begin
      chan = op_ff[0] ? (ev[CW-1:0] | CW'(1)) : ev[CW-1:0];
      if (op_ff[2]) begin
         inc       = 9'($signed(smp));
         hist_addr = {op_ff[2:1], smp ^ SIGN_OFFSET};
      end else begin
         inc       = $signed({1'b0, smp});
         hist_addr = {op_ff[2:1], smp};
      end
      if (mode_ff == MODE_ACC) begin
         spec_addr = {op_ff[2:1], chan};
      end else begin
         spec_addr = {rq_ff, ri_ext[CW-1:0]};
         hist_addr = {rq_ff, ri_ff[7:0]};
      end
   end

   always_comb begin
      sum = (SUM_W+1)'(spec_rd_ff) + (SUM_W+1)'(inc);
      if (sum > (SUM_W+1)'((1 << (SUM_W-1)) - 1)) begin
         sum_sat = SUM_W'((1 << (SUM_W-1)) - 1);
      end else if (sum < -(SUM_W+1)'(1 << (SUM_W-1))) begin
         sum_sat = SUM_W'(-(1 << (SUM_W-1)));
      end else begin
         sum_sat = sum[SUM_W-1:0];
      end
      hist_inc = (hist_rd_ff == '1) ? hist_rd_ff : hist_rd_ff + HIST_W'(1);
   end

   // counters
   always_comb begin
      op_in    = op_ff;
      pair_in  = pair_ff;
      pkt_in   = pkt_ff;
      cmpl_in  = cmpl_ff;
      clr_in   = clr_ff;
      pkt_next = (pkt_ff == '1) ? pkt_ff : pkt_ff + PKT_W'(1);
      if (cmd.load) begin
         op_in = '0;
      end
      if (cmd.clr_init) begin
         pair_in = '0;
         pkt_in  = '0;
         cmpl_in = 1'b0;
         clr_in  = '0;
      end
      if (cmd.clr_step) begin
         clr_in = clr_ff + CLW'(1);
      end
      if (cmd.mem_wr) begin
         op_in = op_ff + 3'd1;
         if (op_ff == 3'd7) begin
            if (last_ff) begin
               pair_in = '0;
               pkt_in  = pkt_next;
               if (pkt_next >= cfg.integrate_count) begin
                  cmpl_in = 1'b1;
               end
            end else if (13'(pair_ff) + 13'd1 >= 13'(PAIRS)) begin
               pair_in = '0;
            end else begin
               pair_in = pair_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= '0;
         pkt_ff  <= '0;
         cmpl_ff <= 1'b0;
         clr_ff  <= '0;
         op_ff   <= '0;
      end else begin
         pair_ff <= pair_in;
         pkt_ff  <= pkt_in;
         cmpl_ff <= cmpl_in;
         clr_ff  <= clr_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_mode);
         smp_ff  <= req_samples;
         last_ff <= req_last;
         rq_ff   <= req_quantity;
         ri_ff   <= req_index;
         drop_ff <= (mode_type'(req_mode) == MODE_ACC) && cmpl_ff;
      end
   end

   // spectrum memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         if ((CLW+1)'(clr_ff) < (CLW+1)'(SPEC_DEPTH)) begin
            spec_mem[clr_ff[SAW-1:0]] <= '0;
         end
      end else if (cmd.mem_wr) begin
         spec_mem[spec_addr] <= sum_sat;
      end
      if (cmd.mem_rd) begin
         spec_rd_ff <= spec_mem[spec_addr];
      end
   end

   // histogram memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         if ((CLW+1)'(clr_ff) < (CLW+1)'(HIST_DEPTH)) begin
            hist_mem[clr_ff[HIST_AW-1:0]] <= '0;
         end
      end else if (cmd.mem_wr && hist_en) begin
         hist_mem[hist_addr] <= hist_inc;
      end
      if (cmd.mem_rd) begin
         hist_rd_ff <= hist_mem[hist_addr];
      end
   end

   always_comb begin
      val = '0;
      if (mode_ff == MODE_RSPEC && spec_ok) begin
         val = VAL_W'(spec_rd_ff);
      end else if (mode_ff == MODE_RHIST && hist_ok) begin
         val = $signed(VAL_W'(hist_rd_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         val_ff   <= val;
         opkt_ff  <= pkt_ff;
         ocmpl_ff <= cmpl_ff;
         odrop_ff <= drop_ff;
      end
   end

   assign rsp_value    = val_ff;
   assign rsp_packets  = opkt_ff;
   assign rsp_complete = ocmpl_ff;
   assign rsp_dropped  = odrop_ff;

   assign sts.mode     = mode_ff;
   assign sts.complete = cmpl_ff;
   assign sts.op_last  = (op_ff == 3'd7);
   assign sts.clr_last = (clr_ff == CLW'(CLR_LEN - 1));

endmodule
